// ===== rtl/core/plcs_pkg.sv =====
// Shared types, codes and helper functions for the pixel linear convert block.
// Depends on nothing; every file of the block imports it.
`default_nettype none

package plcs_pkg;

    // Pixel format codes, used for both the source and the destination.
    typedef enum logic [2:0] {
        FMT_BIT = 3'd0,
        FMT_U8  = 3'd1,
        FMT_S8  = 3'd2,
        FMT_S16 = 3'd3,
        FMT_S32 = 3'd4
    } fmt_t;

    // Register indexes on the configuration port (byte address is 8 * index).
    typedef enum logic [1:0] {
        REG_SRC_FMT = 2'd0,
        REG_DST_FMT = 2'd1,
        REG_GAIN    = 2'd2,
        REG_OFFSET  = 2'd3
    } reg_idx_t;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned FRAC_W     = 16;

    localparam logic [2:0]         SRC_FMT_RESET = 3'd1;
    localparam logic [2:0]         DST_FMT_RESET = 3'd1;
    localparam logic signed [31:0] GAIN_RESET    = 32'sd65536;
    localparam logic signed [47:0] OFFSET_RESET  = 48'sd0;

    typedef struct packed {
        logic signed [31:0] pixel;
        logic               last_of_image;
    } pix_word_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clipped;
        logic               image_clipped;
        logic               last;
    } res_word_t;

    // Reads the low bits of a raw pixel as the given source format.
    function automatic logic signed [31:0] read_source(input logic [2:0] fmt,
                                                       input logic [31:0] raw);
        logic signed [31:0] p;
        begin
            case (fmt)
                FMT_BIT: p = {31'd0, raw[0]};
                FMT_U8:  p = {24'd0, raw[7:0]};
                FMT_S8:  p = {{24{raw[7]}}, raw[7:0]};
                FMT_S16: p = {{16{raw[15]}}, raw[15:0]};
                default: p = raw;
            endcase
            return p;
        end
    endfunction

    // Lowest value of the destination format.
    function automatic logic signed [31:0] dest_lo(input logic [2:0] fmt);
        logic signed [31:0] v;
        begin
            case (fmt)
                FMT_BIT: v = 32'sd0;
                FMT_U8:  v = 32'sd0;
                FMT_S8:  v = -32'sd128;
                FMT_S16: v = -32'sd32768;
                default: v = 32'sh8000_0000;
            endcase
            return v;
        end
    endfunction

    // Highest value of the destination format.
    function automatic logic signed [31:0] dest_hi(input logic [2:0] fmt);
        logic signed [31:0] v;
        begin
            case (fmt)
                FMT_BIT: v = 32'sd1;
                FMT_U8:  v = 32'sd255;
                FMT_S8:  v = 32'sd127;
                FMT_S16: v = 32'sd32767;
                default: v = 32'sh7FFF_FFFF;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pixel_linear_convert_saturate_top.sv =====
// Top level of the pixel linear convert block: configuration registers and
// the four-stage conversion pipeline. Depends on plcs_pkg.
`default_nettype none

// This block converts a stream of pixels, one word per clock unless stalled, from
// a source format to a destination format as value * gain + offset, with gain in
// signed Q16.16 and offset in signed Q32.16. The exact result is rounded to
// the nearest integer with ties to even and saturated to the destination
// range; a word is flagged as clipped when its exact value, before rounding,
// lies outside that range. A sticky image flag collects the clips of the
// current image and is cleared after the word marked as last of its image.
// The pipeline accepts a new pixel every clock while pix_stall is low; one stage
// registers the pixel, one holds the 32 by 32 product, one holds the sum with
// the offset, and the result register holds the rounded, saturated word. Each
// stage moves on whenever the stage after it is empty or moving, so the input
// keeps flowing while a finished result waits for the receiver, and pix_stall
// rises only when all four stages are full. Registers are written over an
// APB-style port at byte addresses 0 (source format), 8 (destination format),
// 16 (gain) and 24 (offset), 64 bits wide; they are meant to change only while
// the block is empty. The unused format codes 5 to 7 act as signed 32-bit.
module pixel_linear_convert_saturate_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [plcs_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [plcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [plcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    // Pixel input channel
    input  wire logic                            pix_valid,
    output logic                                 pix_stall,
    input  wire plcs_pkg::pix_word_t             pix,
    // Result output channel
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output plcs_pkg::res_word_t                  res
);
    import plcs_pkg::*;

    // Configuration registers.
    logic [2:0]         src_fmt_reg;
    logic [2:0]         dst_fmt_reg;
    logic signed [31:0] gain_reg;
    logic signed [47:0] offset_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // Pipeline registers.
    logic               v1_reg;
    pix_word_t          raw_reg;
    logic               v2_reg;
    logic signed [63:0] prod_reg;
    logic               last2_reg;
    logic               v3_reg;
    logic signed [63:0] sum_reg;
    logic               last3_reg;
    logic               ovld_reg;
    res_word_t          res_reg;
    logic               clip_seen_reg;
    logic               clip_seen_next;

    // Stage advance enables.
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv_o;

    // Datapath signals.
    logic signed [31:0] src_val;
    logic signed [63:0] prod_next;
    logic signed [63:0] sum_next;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [63:0] lo_fx;
    logic signed [63:0] hi_fx;
    logic               clip_lo;
    logic               clip_hi;
    logic [47:0]        q;
    logic [15:0]        frac;
    logic               round_up;
    logic [47:0]        q_rnd;
    res_word_t          res_next;

    // ---------------------------------------------------------------------
    // Configuration port. pready is always high, so a write completes in
    // its access cycle.
    // ---------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= SRC_FMT_RESET;
            dst_fmt_reg <= DST_FMT_RESET;
            gain_reg    <= GAIN_RESET;
            offset_reg  <= OFFSET_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SRC_FMT: src_fmt_reg <= pwdata[2:0];
                REG_DST_FMT: dst_fmt_reg <= pwdata[2:0];
                REG_GAIN:    gain_reg    <= pwdata[31:0];
                REG_OFFSET:  offset_reg  <= pwdata[47:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SRC_FMT: prdata = {61'd0, src_fmt_reg};
            REG_DST_FMT: prdata = {61'd0, dst_fmt_reg};
            REG_GAIN:    prdata = {32'd0, gain_reg};
            REG_OFFSET:  prdata = {16'd0, offset_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or its contents move on.
    // ---------------------------------------------------------------------
    assign adv_o     = !ovld_reg || !res_stall;
    assign adv3      = !v3_reg || adv_o;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign pix_stall = !adv1;

    // ---------------------------------------------------------------------
    // Datapath. Stage 1 reads the source format and multiplies by the gain,
    // stage 2 adds the offset, stage 3 clips, rounds and saturates.
    // ---------------------------------------------------------------------
    assign src_val   = read_source(src_fmt_reg, raw_reg.pixel);
    assign prod_next = 64'(src_val) * 64'(gain_reg);
    assign sum_next  = prod_reg + 64'(offset_reg);

    assign lo    = dest_lo(dst_fmt_reg);
    assign hi    = dest_hi(dst_fmt_reg);
    assign lo_fx = {{16{lo[31]}}, lo, 16'h0000};
    assign hi_fx = {{16{hi[31]}}, hi, 16'h0000};

    // The clip test looks at the exact value, before any rounding.
    assign clip_lo = sum_reg < lo_fx;
    assign clip_hi = sum_reg > hi_fx;

    // Round half to even on the 16 fraction bits.
    assign q        = sum_reg[63:FRAC_W];
    assign frac     = sum_reg[FRAC_W-1:0];
    assign round_up = (frac > 16'h8000) || ((frac == 16'h8000) && q[0]);
    assign q_rnd    = q + {47'd0, round_up};

    always_comb
    begin
        res_next.clipped       = clip_lo || clip_hi;
        res_next.image_clipped = clip_lo || clip_hi || clip_seen_reg;
        res_next.last          = last3_reg;
        if (clip_lo)
        begin
            res_next.value = lo;
        end
        else if (clip_hi)
        begin
            res_next.value = hi;
        end
        else
        begin
            res_next.value = q_rnd[31:0];
        end
        clip_seen_next = last3_reg ? 1'b0 : res_next.image_clipped;
    end

    // Valid bits and the sticky clip flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            ovld_reg      <= 1'b0;
            clip_seen_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= pix_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv_o)
            begin
                ovld_reg <= v3_reg;
                if (v3_reg)
                begin
                    clip_seen_reg <= clip_seen_next;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            raw_reg <= pix;
        end
        if (adv2)
        begin
            prod_reg  <= prod_next;
            last2_reg <= raw_reg.last_of_image;
        end
        if (adv3)
        begin
            sum_reg   <= sum_next;
            last3_reg <= last2_reg;
        end
        if (adv_o)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = ovld_reg;
    assign res       = res_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // A clipped word always carries the image flag.
    a_clip_implies_image: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.clipped) |-> res.image_clipped)
        else $error("clipped word without image_clipped");

    // While the last word of an image waits, the sticky flag is already clear.
    a_last_clears_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |-> !clip_seen_reg)
        else $error("sticky clip flag not cleared after last word");

    // The input is held back only when every stage is occupied.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (v1_reg && v2_reg && v3_reg && ovld_reg))
        else $error("input stalled with an empty pipeline stage");

    // A word that leaves stage 3 while the output moves shows up as a result.
    a_stage3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && adv_o) |=> res_valid)
        else $error("result lost between stage 3 and the output register");

endmodule

`default_nettype wire
